// ----- design/irnb_pkg.sv -----
package irnb_pkg;

    localparam int MAX_SRC_WIDTH_D  = 256;
    localparam int MAX_SRC_HEIGHT_D = 256;
    localparam int MAX_CHANNELS_D   = 4;
    localparam int DEST_MAX         = 4096;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_W   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_H   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_W   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_H   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NCH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_X_STEP  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP  = 3'd7;

    typedef struct packed {
        logic       mode;
        logic [7:0] in_c0;
        logic [7:0] in_c1;
        logic [7:0] in_c2;
        logic [7:0] in_c3;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_c0;
        logic [7:0] out_c1;
        logic [7:0] out_c2;
        logic [7:0] out_c3;
        logic       frame_last;
    } t_out_item;

    // emit command handed from the front to the back
    typedef struct packed {
        logic [12:0] lc;
        logic [12:0] lr;
        logic [12:0] hc;
        logic [12:0] hr;
        logic [15:0] wx;
        logic [15:0] wy;
        logic        bilinear;
        logic [2:0]  nch;
        logic        last;
    } t_cmd;

endpackage

// ----- design/image_resize_nearest_bilinear.sv -----
// channel  | signals                                | direction
// input    | i_valid, o_stall, i_data               | in
// output   | o_valid, i_stall, o_data               | out
// config   | i_wr_en, i_wr_idx, i_wr_data           | in
// a load transfer waits while earlier emits still read the pixel memory
// an emit holds the front in S_MUL and S_POS; its result becomes valid after these steps:
// front states, queue pop, four reads of the pixel memory, then B_MIX_H, B_MIX_V and B_OUT
// reset restores the configuration defaults and clears counters and state; pixel memory is undefined until loaded
// a two-entry command queue lets the front run while the output stalls
module image_resize_nearest_bilinear #(
    parameter int MAX_SRC_WIDTH  = irnb_pkg::MAX_SRC_WIDTH_D,
    parameter int MAX_SRC_HEIGHT = irnb_pkg::MAX_SRC_HEIGHT_D,
    parameter int MAX_CHANNELS   = irnb_pkg::MAX_CHANNELS_D
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_en,
    input  logic [2:0]          i_wr_idx,
    input  logic [24:0]         i_wr_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  irnb_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output irnb_pkg::t_out_item o_data
);
    localparam int AW = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT);

    logic           ld_en, cmd_valid, cmd_full, cmd_empty, pop;
    logic           back_busy, rd_busy;
    logic [AW-1:0]  ld_addr;
    logic [31:0]    ld_data;
    logic [12:0]    sw;
    irnb_pkg::t_cmd cmd_in, cmd_out;

    assign rd_busy = !cmd_empty || back_busy;

    irnb_front #(
        .MAX_SRC_WIDTH(MAX_SRC_WIDTH), .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
        .MAX_CHANNELS(MAX_CHANNELS), .AW(AW)
    ) u_front (
        .i_clk, .i_rst_n, .i_wr_en, .i_wr_idx, .i_wr_data,
        .i_valid, .o_stall, .i_data,
        .o_ld_en(ld_en), .o_ld_addr(ld_addr), .o_ld_data(ld_data), .o_sw(sw),
        .o_cmd_valid(cmd_valid), .i_cmd_full(cmd_full), .i_rd_busy(rd_busy),
        .o_cmd(cmd_in)
    );

    irnb_queue u_queue (
        .i_clk, .i_rst_n, .i_push(cmd_valid), .i_cmd(cmd_in), .o_full(cmd_full),
        .i_pop(pop), .o_empty(cmd_empty), .o_cmd(cmd_out)
    );

    irnb_back #(
        .MAX_SRC_WIDTH(MAX_SRC_WIDTH), .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
        .MAX_CHANNELS(MAX_CHANNELS), .AW(AW)
    ) u_back (
        .i_clk, .i_rst_n, .i_ld_en(ld_en), .i_ld_addr(ld_addr), .i_ld_data(ld_data),
        .i_sw(sw), .i_cmd_empty(cmd_empty), .i_cmd(cmd_out), .o_pop(pop),
        .o_busy(back_busy), .o_valid, .i_stall, .o_data
    );
endmodule

// ----- design/irnb_front.sv -----
module irnb_front #(
    parameter int MAX_SRC_WIDTH  = irnb_pkg::MAX_SRC_WIDTH_D,
    parameter int MAX_SRC_HEIGHT = irnb_pkg::MAX_SRC_HEIGHT_D,
    parameter int MAX_CHANNELS   = irnb_pkg::MAX_CHANNELS_D,
    parameter int AW = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_en,
    input  logic [2:0]          i_wr_idx,
    input  logic [24:0]         i_wr_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  irnb_pkg::t_in_item  i_data,
    output logic                o_ld_en,
    output logic [AW-1:0]       o_ld_addr,
    output logic [31:0]         o_ld_data,
    output logic [12:0]         o_sw,
    output logic                o_cmd_valid,
    input  logic                i_cmd_full,
    input  logic                i_rd_busy,
    output irnb_pkg::t_cmd      o_cmd
);
    localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_POS} t_state;

    logic [8:0]  r_src_w, r_src_h;
    logic [12:0] r_dst_w, r_dst_h;
    logic [2:0]  r_nch;
    logic        r_filter;
    logic [24:0] r_x_step, r_y_step;
    logic [AW:0] r_load_ptr;
    logic [11:0] r_col, r_row;
    logic        r_last;
    t_state      r_state;
    logic [37:0] r_cx, r_cy;

    logic [12:0] sw, sh, dw, dh;
    logic [2:0]  nch;
    logic        take, is_load;
    logic [AW:0] n_load_ptr;
    logic [25:0] px_full, py_full;
    logic [37:0] pxv, pyv, cxv, cyv;
    logic [12:0] lc, lr;

    function automatic logic [12:0] sat(input logic [12:0] v, input int hi);
        if (v == 13'd0) return 13'd1;
        if (int'(v) > hi) return 13'(hi);
        return v;
    endfunction

    always_comb begin
        sw  = sat({4'd0, r_src_w}, MAX_SRC_WIDTH);
        sh  = sat({4'd0, r_src_h}, MAX_SRC_HEIGHT);
        dw  = sat(r_dst_w, irnb_pkg::DEST_MAX);
        dh  = sat(r_dst_h, irnb_pkg::DEST_MAX);
        nch = 3'(sat({10'd0, r_nch}, MAX_CHANNELS));
    end

    // a load waits until earlier emits have read the pixel memory
    assign is_load = (i_data.mode == 1'b0);
    assign o_stall = (r_state != S_IDLE) || (is_load ? i_rd_busy : i_cmd_full);
    assign take    = i_valid && !o_stall;
    assign o_sw    = sw;

    assign o_ld_en   = take && is_load;
    assign o_ld_addr = r_load_ptr[AW-1:0];
    assign o_ld_data = {i_data.in_c3, i_data.in_c2, i_data.in_c1, i_data.in_c0};

    always_comb begin
        n_load_ptr = r_load_ptr + 1'b1;
        if ({{(26-AW-1){1'b0}}, n_load_ptr} >= 26'(sw) * 26'(sh)
            || int'(n_load_ptr) >= DEPTH) begin
            n_load_ptr = '0;
        end
    end

    always_comb begin
        cxv = r_cx >> 1;
        cyv = r_cy >> 1;
        pxv = (cxv >= 38'h8000) ? cxv - 38'h8000 : '0;
        pyv = (cyv >= 38'h8000) ? cyv - 38'h8000 : '0;
        if (!r_filter) begin
            pxv = cxv;
            pyv = cyv;
        end
        lc = (pxv[37:16] >= {9'd0, sw}) ? sw - 1'b1 : pxv[28:16];
        lr = (pyv[37:16] >= {9'd0, sh}) ? sh - 1'b1 : pyv[28:16];
        px_full = 26'(pxv[15:0]);
        py_full = 26'(pyv[15:0]);
    end

    always_comb begin
        o_cmd.lc       = lc;
        o_cmd.lr       = lr;
        o_cmd.hc       = (lc + 1'b1 < sw) ? lc + 1'b1 : sw - 1'b1;
        o_cmd.hr       = (lr + 1'b1 < sh) ? lr + 1'b1 : sh - 1'b1;
        o_cmd.wx       = r_filter ? px_full[15:0] : 16'd0;
        o_cmd.wy       = r_filter ? py_full[15:0] : 16'd0;
        o_cmd.bilinear = r_filter;
        o_cmd.nch      = nch;
        o_cmd.last     = r_last;
    end

    assign o_cmd_valid = (r_state == S_POS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w    <= 9'd1;
            r_src_h    <= 9'd1;
            r_dst_w    <= 13'd1;
            r_dst_h    <= 13'd1;
            r_nch      <= 3'd3;
            r_filter   <= 1'b0;
            r_x_step   <= 25'd65536;
            r_y_step   <= 25'd65536;
            r_load_ptr <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_last     <= 1'b0;
            r_state    <= S_IDLE;
        end else begin
            if (i_wr_en) begin
                case (i_wr_idx)
                    irnb_pkg::CFG_SRC_W:  r_src_w  <= i_wr_data[8:0];
                    irnb_pkg::CFG_SRC_H:  r_src_h  <= i_wr_data[8:0];
                    irnb_pkg::CFG_DST_W:  r_dst_w  <= i_wr_data[12:0];
                    irnb_pkg::CFG_DST_H:  r_dst_h  <= i_wr_data[12:0];
                    irnb_pkg::CFG_NCH:    r_nch    <= i_wr_data[2:0];
                    irnb_pkg::CFG_FILTER: r_filter <= i_wr_data[0];
                    irnb_pkg::CFG_X_STEP: r_x_step <= i_wr_data;
                    irnb_pkg::CFG_Y_STEP: r_y_step <= i_wr_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (take && is_load) begin
                        r_load_ptr <= n_load_ptr;
                    end else if (take) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // centre times two, product of 13 by 25 bits
                    r_cx   <= 38'({r_col, 1'b1}) * 38'(r_x_step);
                    r_cy   <= 38'({r_row, 1'b1}) * 38'(r_y_step);
                    r_last <= 1'b0;
                    if ({1'b0, r_col} + 13'd1 >= dw) begin
                        r_col <= '0;
                        if ({1'b0, r_row} + 13'd1 >= dh) begin
                            r_row  <= '0;
                            r_last <= 1'b1;
                        end else begin
                            r_row <= r_row + 1'b1;
                        end
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                    r_state <= S_POS;
                end
                S_POS: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- design/irnb_queue.sv -----
module irnb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  irnb_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output irnb_pkg::t_cmd o_cmd
);
    irnb_pkg::t_cmd r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

// ----- design/irnb_back.sv -----
module irnb_back #(
    parameter int MAX_SRC_WIDTH  = irnb_pkg::MAX_SRC_WIDTH_D,
    parameter int MAX_SRC_HEIGHT = irnb_pkg::MAX_SRC_HEIGHT_D,
    parameter int MAX_CHANNELS   = irnb_pkg::MAX_CHANNELS_D,
    parameter int AW = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ld_en,
    input  logic [AW-1:0]       i_ld_addr,
    input  logic [31:0]         i_ld_data,
    input  logic [12:0]         i_sw,
    input  logic                i_cmd_empty,
    input  irnb_pkg::t_cmd      i_cmd,
    output logic                o_pop,
    output logic                o_busy,
    output logic                o_valid,
    input  logic                i_stall,
    output irnb_pkg::t_out_item o_data
);
    typedef enum logic [2:0] {B_IDLE, B_RD, B_MIX_H, B_MIX_V, B_OUT} t_bstate;

    logic [31:0]    r_mem [2**AW];
    logic [31:0]    r_rd;
    t_bstate        r_state;
    irnb_pkg::t_cmd r_cmd;
    logic [1:0]     r_tap;
    logic [1:0]     r_tap_d;
    logic           r_rd_ok;
    logic [7:0]     r_pix [4][4];
    logic [23:0]    r_top [4];
    logic [23:0]    r_bot [4];
    logic [7:0]     r_res [4];
    logic           r_valid;
    irnb_pkg::t_out_item r_out;

    logic [12:0]    rrow, rcol;
    logic [25:0]    addr;
    logic [16:0]    iwx, iwy;

    always_comb begin
        rrow = r_tap[1] ? r_cmd.hr : r_cmd.lr;
        rcol = r_tap[0] ? r_cmd.hc : r_cmd.lc;
        addr = 26'(rrow) * 26'(i_sw) + 26'(rcol);
        iwx  = 17'h10000 - 17'(r_cmd.wx);
        iwy  = 17'h10000 - 17'(r_cmd.wy);
    end

    assign o_pop  = (r_state == B_IDLE) && !i_cmd_empty && !r_valid;
    assign o_busy = (r_state != B_IDLE);

    always_ff @(posedge i_clk) begin
        if (i_ld_en) begin
            r_mem[i_ld_addr] <= i_ld_data;
        end
        r_rd <= r_mem[addr[AW-1:0]];
    end

    // one memory read a cycle, four taps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
            r_rd_ok <= 1'b0;
            r_tap   <= '0;
        end else begin
            if (r_valid && !i_stall) r_valid <= 1'b0;
            r_rd_ok <= (r_state == B_RD);
            r_tap_d <= r_tap;
            if (r_rd_ok) begin
                for (int k = 0; k < 4; k++) r_pix[r_tap_d][k] <= r_rd[8*k +: 8];
            end
            case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        r_cmd   <= i_cmd;
                        r_tap   <= '0;
                        r_state <= B_RD;
                    end
                end
                B_RD: begin
                    r_tap <= r_tap + 1'b1;
                    if (r_tap == 2'd3) r_state <= B_MIX_H;
                end
                B_MIX_H: begin
                    r_state <= B_MIX_V;
                end
                B_MIX_V: begin
                    for (int k = 0; k < 4; k++) begin
                        r_top[k] <= 24'(r_pix[0][k]) * 24'(iwx)
                                    + 24'(r_pix[1][k]) * 24'(r_cmd.wx);
                        r_bot[k] <= 24'(r_pix[2][k]) * 24'(iwx)
                                    + 24'(r_pix[3][k]) * 24'(r_cmd.wx);
                    end
                    r_state <= B_OUT;
                end
                B_OUT: begin
                    for (int k = 0; k < 4; k++) begin
                        r_res[k] <= 8'((41'(r_top[k]) * iwy + 41'(r_bot[k]) * r_cmd.wy) >> 32);
                    end
                    r_state <= B_IDLE;
                    r_valid <= 1'b1;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_comb begin
        r_out.out_c0     = (r_cmd.nch > 3'd0) ? r_res[0] : 8'd0;
        r_out.out_c1     = (r_cmd.nch > 3'd1) ? r_res[1] : 8'd0;
        r_out.out_c2     = (r_cmd.nch > 3'd2) ? r_res[2] : 8'd0;
        r_out.out_c3     = (r_cmd.nch > 3'd3) ? r_res[3] : 8'd0;
        r_out.frame_last = r_cmd.last;
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;
endmodule
